/* hdl/tun_pkg.sv */
package tun_pkg;

  localparam int COORD_WIDTH = 24;

  // derived widths
  localparam int EW   = COORD_WIDTH + 1;        // edge
  localparam int PW   = 2 * EW;                 // edge product
  localparam int CRW  = PW + 1;                 // cross component, signed
  localparam int MW   = 2 * COORD_WIDTH + 1;    // cross magnitude
  localparam int LW   = (MW + 1) / 2;           // low split of magnitude
  localparam int HW   = MW - LW;                // high split of magnitude
  localparam int SW   = 2 * MW;                 // square
  localparam int SUMW = SW + 2;                 // sum of three squares
  localparam int RW   = SUMW / 2;               // root
  localparam int QW   = 15;                     // quotient bits
  localparam int DW   = MW + QW + 1;            // divider remainder
  localparam int TOLW = 20;
  localparam int NW   = 16;

  // pipeline stage map
  localparam int ST_MAG = 3;
  localparam int ST_SQ0 = 7;
  localparam int ST_DV0 = ST_SQ0 + RW;
  localparam int NST    = ST_DV0 + QW;

  localparam logic signed [NW-1:0] NORM_ONE = NW'(32767);

  typedef struct packed {
    logic [2:0]         neg;
    logic [2:0][MW-1:0] mag;
    logic               degen;
  } side_t;

  typedef struct packed {
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [NW-1:0] nz;
    logic                 degen;
  } res_t;

endpackage

/* hdl/tun_in_if.sv */
interface tun_in_if import tun_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] first_z;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;
  logic signed [COORD_WIDTH-1:0] second_z;
  logic signed [COORD_WIDTH-1:0] third_x;
  logic signed [COORD_WIDTH-1:0] third_y;
  logic signed [COORD_WIDTH-1:0] third_z;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  third_x, third_y, third_z, input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                third_x, third_y, third_z, output ready);
endinterface

/* hdl/tun_out_if.sv */
interface tun_out_if import tun_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [NW-1:0] normal_x;
  logic signed [NW-1:0] normal_y;
  logic signed [NW-1:0] normal_z;
  logic                 degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

/* hdl/triangle_unit_normal.sv */
// Unit face normal of a triangle. A request carries three vertices in signed
// Q12.12; the result is the normal of (v2-v0) x (v1-v0) in signed Q1.15,
// each component truncated toward zero and held to +/-32767. When no cross
// product component exceeds cfg zero_tolerance (raw Q24.24) the result is
// (32767,0,0) with degenerate set. The block is a 72-stage pipeline plus an
// output register: 7 stages of edge, cross product and square arithmetic, one
// stage per root bit of the exact integer square root (50) and one stage per
// quotient bits of the three divisions (15). It takes a request every cycle
// while the pipeline is not stalled. A two-entry output buffer lets the
// pipeline keep going while a result waits; it stalls only when both entries
// are full. Write the tolerance only while no request is in flight.
module triangle_unit_normal import tun_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tun_in_if.sink            in_chan,
  tun_out_if.source         out_chan,
  input  logic              cfg_we,
  input  logic [TOLW-1:0]   cfg_wdata
);

  logic [TOLW-1:0] tol_r;
  logic [NST-1:0]  v_r;
  logic            en;

  // stage registers
  logic signed [EW-1:0]  e_r   [6];
  logic signed [PW-1:0]  p_r   [6];
  logic signed [CRW-1:0] c_r   [3];
  side_t                 side_r [ST_MAG:NST-1];
  logic [2*HW-1:0]       hh_r  [3];
  logic [HW+LW-1:0]      hl_r  [3];
  logic [2*LW-1:0]       ll_r  [3];
  logic [SW-1:0]         sq_r  [3];
  logic [SUMW-1:0]       sum_r;
  logic [RW-1:0]         rt_r  [RW];
  logic [RW+1:0]         rm_r  [RW];
  logic [SUMW-1:0]       bt_r  [RW];
  logic [QW-1:0]         q_r   [QW][3];
  logic [DW-1:0]         dr_r  [QW][3];
  logic [RW-1:0]         dl_r  [QW];

  // output register and skid entry
  res_t out_r, skid_r, res;
  logic out_v_r, skid_v_r;

  // pipeline moves as one while the skid entry is free
  assign en           = !skid_v_r;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_chan.valid};
    end
  end

  // edges, edge products, cross components
  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= EW'(in_chan.third_x) - EW'(in_chan.first_x);
      e_r[1] <= EW'(in_chan.third_y) - EW'(in_chan.first_y);
      e_r[2] <= EW'(in_chan.third_z) - EW'(in_chan.first_z);
      e_r[3] <= EW'(in_chan.second_x) - EW'(in_chan.first_x);
      e_r[4] <= EW'(in_chan.second_y) - EW'(in_chan.first_y);
      e_r[5] <= EW'(in_chan.second_z) - EW'(in_chan.first_z);
      p_r[0] <= e_r[1] * e_r[5];
      p_r[1] <= e_r[2] * e_r[4];
      p_r[2] <= e_r[2] * e_r[3];
      p_r[3] <= e_r[0] * e_r[5];
      p_r[4] <= e_r[0] * e_r[4];
      p_r[5] <= e_r[1] * e_r[3];
      c_r[0] <= CRW'(p_r[0]) - CRW'(p_r[1]);
      c_r[1] <= CRW'(p_r[2]) - CRW'(p_r[3]);
      c_r[2] <= CRW'(p_r[4]) - CRW'(p_r[5]);
    end
  end

  // magnitude, sign and tolerance test
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        side_r[ST_MAG].neg[i] <= c_r[i][CRW-1];
        side_r[ST_MAG].mag[i] <= c_r[i][CRW-1] ? MW'(-c_r[i]) : MW'(c_r[i]);
      end
      side_r[ST_MAG].degen <=
        ((c_r[0][CRW-1] ? MW'(-c_r[0]) : MW'(c_r[0])) <= MW'(tol_r)) &&
        ((c_r[1][CRW-1] ? MW'(-c_r[1]) : MW'(c_r[1])) <= MW'(tol_r)) &&
        ((c_r[2][CRW-1] ? MW'(-c_r[2]) : MW'(c_r[2])) <= MW'(tol_r));
    end
  end

  for (genvar s = ST_MAG + 1; s < NST; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) side_r[s] <= side_r[s-1];
    end
  end

  // squares from split partial products, then the sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= side_r[ST_MAG].mag[i][MW-1:LW] * side_r[ST_MAG].mag[i][MW-1:LW];
        hl_r[i] <= side_r[ST_MAG].mag[i][MW-1:LW] * side_r[ST_MAG].mag[i][LW-1:0];
        ll_r[i] <= side_r[ST_MAG].mag[i][LW-1:0] * side_r[ST_MAG].mag[i][LW-1:0];
        sq_r[i] <= (SW'(hh_r[i]) << (2 * LW)) + (SW'(hl_r[i]) << (LW + 1)) + SW'(ll_r[i]);
      end
      sum_r <= SUMW'(sq_r[0]) + SUMW'(sq_r[1]) + SUMW'(sq_r[2]);
    end
  end

  // integer square root, one root bit per stage
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    logic [RW-1:0]   rt_in;
    logic [RW+1:0]   rm_in;
    logic [SUMW-1:0] bt_in;
    logic [RW+3:0]   rm_sh, trial;
    if (j == 0) begin : g_first
      assign rt_in = '0;
      assign rm_in = '0;
      assign bt_in = sum_r;
    end else begin : g_next
      assign rt_in = rt_r[j-1];
      assign rm_in = rm_r[j-1];
      assign bt_in = bt_r[j-1];
    end
    assign rm_sh = {rm_in, bt_in[SUMW-1 -: 2]};
    assign trial = (RW+4)'({rt_in, 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        bt_r[j] <= bt_in << 2;
        if (rm_sh >= trial) begin
          rm_r[j] <= (RW+2)'(rm_sh - trial);
          rt_r[j] <= {rt_in[RW-2:0], 1'b1};
        end else begin
          rm_r[j] <= (RW+2)'(rm_sh);
          rt_r[j] <= {rt_in[RW-2:0], 1'b0};
        end
      end
    end
  end

  // restoring division of mag * 2^15 by the root, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [RW-1:0] l_in;
    logic [DW-1:0] d_step;
    logic [DW-1:0] r_in [3];
    logic [QW-1:0] q_in [3];
    if (k == 0) begin : g_first
      assign l_in = rt_r[RW-1];
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign r_in[c] = DW'(side_r[ST_DV0-1].mag[c]) << QW;
        assign q_in[c] = '0;
      end
    end else begin : g_next
      assign l_in = dl_r[k-1];
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign r_in[c] = dr_r[k-1][c];
        assign q_in[c] = q_r[k-1][c];
      end
    end
    assign d_step = DW'(l_in) << (QW - 1 - k);
    always_ff @(posedge clk) begin
      if (en) begin
        dl_r[k] <= l_in;
        for (int c = 0; c < 3; c++) begin
          if (r_in[c] >= d_step) begin
            dr_r[k][c] <= r_in[c] - d_step;
            q_r[k][c]  <= q_in[c] | (QW'(1) << (QW - 1 - k));
          end else begin
            dr_r[k][c] <= r_in[c];
            q_r[k][c]  <= q_in[c];
          end
        end
      end
    end
  end

  // signed result out of the last stage
  always_comb begin
    res.degen = side_r[NST-1].degen;
    if (side_r[NST-1].degen) begin
      res.nx = NORM_ONE;
      res.ny = '0;
      res.nz = '0;
    end else begin
      res.nx = side_r[NST-1].neg[0] ? -NW'(q_r[QW-1][0]) : NW'(q_r[QW-1][0]);
      res.ny = side_r[NST-1].neg[1] ? -NW'(q_r[QW-1][1]) : NW'(q_r[QW-1][1]);
      res.nz = side_r[NST-1].neg[2] ? -NW'(q_r[QW-1][2]) : NW'(q_r[QW-1][2]);
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_chan.ready) begin
      if (v_r[NST-1] && en) skid_v_r <= 1'b1;
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_chan.ready) begin
      if (en) skid_r <= res;
    end else if (skid_v_r) begin
      out_r <= skid_r;
    end else begin
      out_r <= res;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.normal_x   = out_r.nx;
  assign out_chan.normal_y   = out_r.ny;
  assign out_chan.normal_z   = out_r.nz;
  assign out_chan.degenerate = out_r.degen;

  // skid entry only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid entry full with output empty");

  // degenerate result is always the fixed axis
  a_degen_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.degen |-> out_r.nx == NORM_ONE && out_r.ny == '0 && out_r.nz == '0)
    else $error("degenerate result not (1,0,0)");

  // components never reach -1.0
  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r.nx != -NORM_ONE - NW'(1) && out_r.ny != -NORM_ONE - NW'(1)
                && out_r.nz != -NORM_ONE - NW'(1))
    else $error("normal component out of Q1.15 range");

  // square root remainder stays within 2*root
  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_DV0-1] |-> (RW+2)'(rm_r[RW-1]) <= (RW+2)'({rt_r[RW-1], 1'b0}))
    else $error("square root remainder too large");

endmodule
